// ===== sv/agbsf_pkg.sv =====
// shared types and constants for the alignment group best-score filter
// used by alignment_group_best_score_filter_top; no dependencies
package agbsf_pkg;

    localparam int MAX_GROUP = 64;
    localparam int GROUP_AW  = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);

    localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [1:0] CFG_MIN_SCORE   = 2'd1;
    localparam logic [1:0] CFG_MAX_SCORE   = 2'd2;
    localparam logic [1:0] CFG_PCT_FACTOR  = 2'd3;

    localparam logic [1:0] MODE_TOP_ALL  = 2'd0;
    localparam logic [1:0] MODE_TOP_RAND = 2'd1;
    localparam logic [1:0] MODE_PCT      = 2'd2;
    localparam logic [1:0] MODE_KEEP_INB = 2'd3;

    typedef struct packed {
        logic [31:0] score;
        logic        score_not_finite;
        logic        last_in_group;
        logic [30:0] random_value;
    } t_in_req;

    typedef struct packed {
        logic       keep;
        logic [5:0] slot;
        logic       last_of_group;
        logic       query_passed;
        logic [6:0] dropped_count;
        logic       overflow;
    } t_out_req;

endpackage

// ===== sv/alignment_group_best_score_filter_top.sv =====
// alignment group best-score filter: buffer, scan and emit logic
// depends on agbsf_pkg
//
// usage: alignments of one query arrive as requests on i_in_valid / o_in_stall,
// one score each, the final one flagged last_in_group. every request taken is
// stored in a 64-entry score memory (one write port, one registered read port);
// requests past 64 are dropped and flagged. on the last request the block
// stalls its input and walks the memory twice: a scan pass through the states
// read, evaluate and compare for each stored alignment (plus a remainder step
// for every top-scoring alignment in random mode, done by the bit-serial
// remainder unit), then an emit pass through read, evaluate and compare for
// each result, each result held in an output register until taken on
// o_out_valid / i_out_stall. a stalled result holds the emit walk; the input
// stays stalled until the last result is loaded. configuration writes on
// i_cfg_we must only happen idle. reset is synchronous, active low: group state
// clears and registers return to mode 0, min 0, max all ones, pct factor 1.0.
module alignment_group_best_score_filter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  agbsf_pkg::t_in_req i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output agbsf_pkg::t_out_req o_out
);
    import agbsf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_P_RD, ST_P_EV, ST_P_CMP, ST_P_DIV, ST_P_FIX,
        ST_E_RD, ST_E_EV, ST_E_CMP
    } t_state;

    t_state           r_state;
    logic [1:0]       r_mode;
    logic [31:0]      r_min, r_max, r_pct;
    logic [62:0]      r_mem [MAX_GROUP];
    logic [62:0]      r_mem_q;
    logic [CNT_W-1:0] r_count, r_inb_cnt, r_idx, r_kept, r_seen;
    logic [31:0]      r_best;
    logic             r_ovf, r_use_first;
    logic [GROUP_AW-1:0] r_first, r_pick;
    logic             r_inb, r_eq;
    logic [63:0]      r_prod;
    logic [30:0]      r_rnd, r_div_q;
    logic [CNT_W-1:0] r_rem;
    logic [4:0]       r_div_cnt;
    logic             r_out_valid;
    t_out_req         r_out;

    logic [31:0]      s_score, s_v;
    logic             s_in_acc, s_in_inb, s_k, s_out_free, s_idx_last, s_keep;
    logic [CNT_W:0]   s_div_t;
    logic [CNT_W-1:0] s_div_rem;
    logic [CNT_W-1:0] s_idx_inc;

    assign s_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign s_score    = i_in.score_not_finite ? 32'd0 : i_in.score;
    assign s_in_inb   = (s_score >= r_min) && (s_score <= r_max);
    assign s_v        = r_mem_q[31:0];
    assign s_idx_inc  = r_idx + CNT_W'(1);
    assign s_idx_last = (s_idx_inc == r_count);
    assign s_out_free = !r_out_valid || !i_out_stall;
    assign s_div_t    = {r_rem, r_div_q[30]};
    assign s_div_rem  = (s_div_t >= {1'b0, r_seen}) ? CNT_W'(s_div_t - {1'b0, r_seen})
                                                    : s_div_t[CNT_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        case (r_mode)
            MODE_TOP_ALL:  s_k = r_inb && r_eq;
            MODE_TOP_RAND: s_k = 1'b0;
            MODE_PCT:      s_k = r_inb && (r_prod <= {16'd0, r_best, 16'd0});
            default:       s_k = r_inb;
        endcase
    end

    always_comb begin
        if (r_inb_cnt == '0) begin
            s_keep = 1'b0;
        end else if (r_mode == MODE_TOP_RAND) begin
            s_keep = (r_idx[GROUP_AW-1:0] == r_pick);
        end else begin
            s_keep = s_k || (r_use_first && (r_idx[GROUP_AW-1:0] == r_first));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TOP_ALL;
            r_min  <= 32'd0;
            r_max  <= 32'hFFFF_FFFF;
            r_pct  <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILTER_MODE: r_mode <= i_cfg_data[1:0];
                CFG_MIN_SCORE:   r_min  <= i_cfg_data;
                CFG_MAX_SCORE:   r_max  <= i_cfg_data;
                CFG_PCT_FACTOR:  r_pct  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_acc && (r_count < CNT_W'(MAX_GROUP))) begin
            r_mem[r_count[GROUP_AW-1:0]] <= {i_in.random_value, s_score};
        end
        if (r_state == ST_P_RD || r_state == ST_E_RD) begin
            r_mem_q <= r_mem[r_idx[GROUP_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_P_EV || r_state == ST_E_EV) begin
            r_inb  <= (s_v >= r_min) && (s_v <= r_max);
            r_eq   <= (s_v == r_best);
            r_prod <= 64'(s_v) * 64'(r_pct);
            r_rnd  <= r_mem_q[62:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_inb_cnt   <= '0;
            r_best      <= 32'd0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_kept      <= '0;
            r_seen      <= '0;
            r_use_first <= 1'b0;
            r_first     <= '0;
            r_pick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != ST_E_CMP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_in_acc) begin
                        if (r_count < CNT_W'(MAX_GROUP)) begin
                            r_count <= r_count + CNT_W'(1);
                            if (s_in_inb) begin
                                if (r_inb_cnt == '0 || s_score < r_best) begin
                                    r_best <= s_score;
                                end
                                if (r_inb_cnt == '0) begin
                                    r_first <= r_count[GROUP_AW-1:0];
                                end
                                r_inb_cnt <= r_inb_cnt + CNT_W'(1);
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.last_in_group) begin
                            r_state     <= ST_P_RD;
                            r_idx       <= '0;
                            r_kept      <= '0;
                            r_seen      <= '0;
                            r_use_first <= 1'b0;
                        end
                    end
                end
                ST_P_RD: r_state <= ST_P_EV;
                ST_P_EV: r_state <= ST_P_CMP;
                ST_P_CMP: begin
                    r_kept <= r_kept + CNT_W'(s_k);
                    if (r_mode == MODE_TOP_RAND && r_inb && r_eq) begin
                        r_seen    <= r_seen + CNT_W'(1);
                        r_div_q   <= r_rnd;
                        r_rem     <= '0;
                        r_div_cnt <= 5'd0;
                        r_state   <= ST_P_DIV;
                    end else begin
                        r_idx   <= s_idx_inc;
                        r_state <= s_idx_last ? ST_P_FIX : ST_P_RD;
                    end
                end
                ST_P_DIV: begin
                    r_rem     <= s_div_rem;
                    r_div_q   <= {r_div_q[29:0], 1'b0};
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd30) begin
                        if (s_div_rem == '0) begin
                            r_pick <= r_idx[GROUP_AW-1:0];
                        end
                        r_idx   <= s_idx_inc;
                        r_state <= s_idx_last ? ST_P_FIX : ST_P_RD;
                    end
                end
                ST_P_FIX: begin
                    if (r_inb_cnt == '0) begin
                        r_kept <= '0;
                    end else if (r_mode == MODE_TOP_RAND || r_kept == '0) begin
                        r_kept      <= CNT_W'(1);
                        r_use_first <= (r_mode != MODE_TOP_RAND);
                    end
                    r_idx   <= '0;
                    r_state <= ST_E_RD;
                end
                ST_E_RD: r_state <= ST_E_EV;
                ST_E_EV: r_state <= ST_E_CMP;
                ST_E_CMP: begin
                    if (s_out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.keep          <= s_keep;
                        r_out.slot          <= r_idx[5:0];
                        r_out.last_of_group <= s_idx_last;
                        r_out.query_passed  <= (r_inb_cnt != '0);
                        r_out.dropped_count <= 7'(r_count - r_kept);
                        r_out.overflow      <= r_ovf;
                        r_idx               <= s_idx_inc;
                        if (s_idx_last) begin
                            r_count   <= '0;
                            r_inb_cnt <= '0;
                            r_best    <= 32'd0;
                            r_ovf     <= 1'b0;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_state <= ST_E_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_GROUP)) else $error("group count past capacity");
    a_inb_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inb_cnt <= r_count) else $error("in-bounds count past group count");
    a_busy_has_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_count != '0) else $error("walk with empty group");
    a_keep_passed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.keep |-> r_out.query_passed) else $error("keep without pass");
`endif

endmodule
